/* rtl/core/mbfe_pkg.sv */
// shared constants, codes and item types for the message bit field engine
package mbfe_pkg;

  // store geometry
  localparam int unsigned STORE_BYTES    = 1024;
  localparam int unsigned MAX_FIELD_BITS = 32;
  localparam int unsigned STORE_BITS     = 8 * STORE_BYTES;
  localparam int unsigned NUM_WORDS      = STORE_BYTES / 4;
  localparam int unsigned BANK_DEPTH     = NUM_WORDS / 2;
  localparam int unsigned WORD_AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int unsigned BANK_AW        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  // bit position width inside the datapath (byte address times eight fits too)
  localparam int unsigned POS_W = 13;

  // action codes
  localparam logic [2:0] ACT_LOAD  = 3'd0;
  localparam logic [2:0] ACT_RD_U  = 3'd1;
  localparam logic [2:0] ACT_RD_S  = 3'd2;
  localparam logic [2:0] ACT_WR_U  = 3'd3;
  localparam logic [2:0] ACT_WR_S  = 3'd4;

  // status codes
  localparam logic ST_DONE  = 1'b0;
  localparam logic ST_RANGE = 1'b1;

  typedef struct packed {
    logic [2:0]  action;
    logic [9:0]  byte_addr;
    logic [7:0]  byte_data;
    logic [12:0] bit_pos;
    logic [5:0]  field_len;
    logic [31:0] write_value;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic        status;
  } out_item_t;

  // decoded operation handed to the field unit
  typedef struct packed {
    logic        is_read;
    logic        is_signed;
    logic        is_write;
    logic        sgn_write;
    logic [5:0]  len;
    logic [4:0]  ofs;
    logic [31:0] value;
  } field_op_t;

  // field unit result: merged word pair, write strobes and read value
  typedef struct packed {
    logic [63:0] pair;
    logic        we_hi;
    logic        we_lo;
    logic [31:0] read_value;
  } field_res_t;

endpackage

/* rtl/core/mbfe_ram.sv */
// generic single-clock ram, one write port and one registered read port
module mbfe_ram #(
  parameter  int unsigned WIDTH = 32,
  parameter  int unsigned DEPTH = 128,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/mbfe_bit_field.sv */
// field extract and insert over a pair of adjacent 32-bit store words
module mbfe_bit_field (
  input  mbfe_pkg::field_op_t  op,
  input  logic [63:0]          pair,
  output mbfe_pkg::field_res_t res
);
  import mbfe_pkg::*;

  logic [31:0] mask;
  logic [31:0] top_bit;
  logic [6:0]  sh;
  logic [31:0] ext;
  logic [31:0] ext_sx;
  logic [31:0] wv;
  logic [6:0]  end_bit;

  // field mask and its top bit
  assign mask    = 32'((33'd1 << op.len) - 33'd1);
  assign top_bit = mask ^ (mask >> 1);

  // distance from the field's last bit to the pair's lsb
  assign sh      = 7'd64 - 7'(op.ofs) - 7'(op.len);
  assign end_bit = 7'(op.ofs) + 7'(op.len);

  // extract, then sign-extend from the field's top bit
  assign ext    = 32'(pair >> sh) & mask;
  assign ext_sx = (op.is_signed && ((ext & top_bit) != 32'd0)) ? (ext | ~mask) : ext;

  // signed write forces the top field bit to the value's sign
  always_comb begin
    wv = op.value;
    if (op.sgn_write) begin
      wv = op.value[31] ? (op.value | top_bit) : (op.value & ~top_bit);
    end
  end

  // merge into the pair and select outputs
  always_comb begin
    res.pair       = (pair & ~({32'd0, mask} << sh)) | ({32'd0, wv & mask} << sh);
    res.we_hi      = op.is_write;
    res.we_lo      = op.is_write && (end_bit > 7'd32);
    res.read_value = op.is_read ? ext_sx : 32'd0;
  end

endmodule

/* rtl/core/message_bit_field_engine.sv */
// top level of the message bit field engine: decode, banked store, result register
//
// Holds a 1024-byte message store with msb-first bit numbering. Each item on
// the in_ channel loads one byte, reads a field of 0 to 32 bits (unsigned or
// sign-extended) or writes one; every item gives exactly one item on the out_
// channel with the read value and a status bit (1: out of range, ignored).
// The store is two word-interleaved 32-bit rams (even and odd words), so any
// field of up to 32 bits lies in one word pair that both rams read together.
// Timing: the item is accepted and both rams are read at the same edge; the
// next cycle merges the field, writes the touched words back and loads the
// result register. No new item is taken during that work cycle, so an item is
// through the write-back before the next is accepted. An item is accepted
// while a result waits, as long as that result leaves at the same edge; a
// stalled result holds back the next item.
// Reset clears the control state and the result valid and stalls the input;
// the store contents are undefined until written and have no clearing pass.
module message_bit_field_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mbfe_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output mbfe_pkg::out_item_t out_item
);
  import mbfe_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_WORK = 1'b1;

  logic               state_r, state_nxt;
  logic               in_acc;
  field_op_t          op_d, op_r;
  logic               status_d, status_r;
  logic [POS_W-1:0]   pos_d;
  logic [WORD_AW-1:0] word_d, word1_d;
  logic               w0_r;
  logic [BANK_AW-1:0] even_addr_d, odd_addr_d, even_addr_r, odd_addr_r;
  logic [31:0]        even_q, odd_q;
  logic [63:0]        pair;
  field_res_t         fres;
  logic               even_we, odd_we;
  logic [31:0]        even_wd, odd_wd;
  logic               bad_field, bad_addr;
  logic               out_valid_r;
  out_item_t          out_item_r;

  // handshake: one item at a time, output slot must be free by the next edge
  assign in_stall = !rst_n || (state_r == S_WORK) || (out_valid_r && out_stall);
  assign in_acc   = in_valid && !in_stall;

  // range checks
  assign bad_field = (32'(in_item.field_len) > MAX_FIELD_BITS) ||
                     (32'(in_item.bit_pos) + 32'(in_item.field_len) > STORE_BITS);
  assign bad_addr  = 32'(in_item.byte_addr) >= STORE_BYTES;

  // action decode; a byte load becomes an eight-bit field write
  always_comb begin
    op_d      = '0;
    status_d  = ST_DONE;
    pos_d     = in_item.bit_pos;
    op_d.len  = in_item.field_len;
    op_d.value = in_item.write_value;
    unique case (in_item.action) inside
      ACT_LOAD: begin
        pos_d         = {in_item.byte_addr, 3'b000};
        op_d.len      = 6'd8;
        op_d.value    = {24'd0, in_item.byte_data};
        op_d.is_write = !bad_addr;
        status_d      = bad_addr ? ST_RANGE : ST_DONE;
      end
      ACT_RD_U, ACT_RD_S: begin
        op_d.is_read   = !bad_field;
        op_d.is_signed = (in_item.action == ACT_RD_S);
        status_d       = bad_field ? ST_RANGE : ST_DONE;
      end
      ACT_WR_U, ACT_WR_S: begin
        op_d.is_write  = !bad_field && (in_item.field_len != 6'd0);
        op_d.sgn_write = (in_item.action == ACT_WR_S);
        status_d       = bad_field ? ST_RANGE : ST_DONE;
      end
      default: begin
        op_d.len = 6'd0;
      end
    endcase
    op_d.ofs = pos_d[4:0];
  end

  // word pair addresses: odd bank holds word>>1 when odd, the next word otherwise
  assign word_d      = WORD_AW'(pos_d >> 5);
  assign word1_d     = word_d + WORD_AW'(1);
  assign even_addr_d = BANK_AW'(word1_d >> 1);
  assign odd_addr_d  = BANK_AW'(word_d >> 1);

  // store banks
  mbfe_ram #(.WIDTH(32), .DEPTH(BANK_DEPTH)) u_even_ram (
    .clk   (clk),
    .we    (even_we),
    .waddr (even_addr_r),
    .wdata (even_wd),
    .re    (in_acc),
    .raddr (even_addr_d),
    .rdata (even_q)
  );

  mbfe_ram #(.WIDTH(32), .DEPTH(BANK_DEPTH)) u_odd_ram (
    .clk   (clk),
    .we    (odd_we),
    .waddr (odd_addr_r),
    .wdata (odd_wd),
    .re    (in_acc),
    .raddr (odd_addr_d),
    .rdata (odd_q)
  );

  // captured item for the work cycle
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r        <= op_d;
      status_r    <= status_d;
      w0_r        <= word_d[0];
      even_addr_r <= even_addr_d;
      odd_addr_r  <= odd_addr_d;
    end
  end

  // word pair in message order, first word in the high half
  assign pair = w0_r ? {odd_q, even_q} : {even_q, odd_q};

  mbfe_bit_field u_bit_field (
    .op   (op_r),
    .pair (pair),
    .res  (fres)
  );

  // write-back of the touched words
  always_comb begin
    even_we = 1'b0;
    odd_we  = 1'b0;
    if (state_r == S_WORK) begin
      even_we = w0_r ? fres.we_lo : fres.we_hi;
      odd_we  = w0_r ? fres.we_hi : fres.we_lo;
    end
    even_wd = w0_r ? fres.pair[31:0] : fres.pair[63:32];
    odd_wd  = w0_r ? fres.pair[63:32] : fres.pair[31:0];
  end

  // control state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_WORK;
        end
      end
      S_WORK: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_WORK) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_WORK) begin
      out_item_r.read_value <= fres.read_value;
      out_item_r.status     <= status_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // checks
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_acc) else $error("item accepted in the work cycle");

  a_work_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WORK) |=> out_valid_r) else $error("work cycle left no result");

  a_write_only_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    (even_we || odd_we) |-> (state_r == S_WORK && op_r.is_write))
    else $error("store written outside a field write");

  a_range_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.status == ST_RANGE) |-> (out_item_r.read_value == 32'd0))
    else $error("ignored item returned data");

endmodule
